/* rtl/double_ended_queue_core_assert.svh */
// Assertion macros shared by the checker of the double-ended queue.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed in the same cycle");

// The consequent holds in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed one cycle later");

`endif

/* rtl/deq_pkg.sv */
// Package of the double-ended queue: codes, control types and the microcode table.
// Used by deq_seq, double_ended_queue_core and deq_checker; depends on nothing.
`default_nettype none

package deq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int WORD_W       = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_DUMP_FWD   = 3'd4;
	localparam logic [2:0] OP_DUMP_BWD   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [3:0] {
		STEP_FETCH,
		STEP_PUSH_FRONT,
		STEP_PUSH_BACK,
		STEP_POP_FRONT,
		STEP_POP_BACK,
		STEP_POP_EMIT,
		STEP_DUMP,
		STEP_DUMP_READ,
		STEP_DUMP_EMIT
	} step_t;

	typedef enum logic [1:0] {CHK_NONE, CHK_FULL, CHK_EMPTY} chk_t;

	typedef enum logic [2:0] {
		ADDR_FRONT,
		ADDR_FRONT_DEC,
		ADDR_BACK,
		ADDR_BACK_LAST,
		ADDR_DUMP
	} asel_t;

	typedef enum logic [1:0] {PTR_HOLD, PTR_INC, PTR_DEC, PTR_CLR} ptr_op_t;

	typedef enum logic [1:0] {EMIT_NONE, EMIT_ZERO, EMIT_MEM} emit_t;

	typedef enum logic {NEXT_GOTO, NEXT_LOOP} nmode_t;

	typedef struct packed {
		chk_t    chk;
		logic    wr;
		logic    rd;
		asel_t   asel;
		ptr_op_t fop;
		ptr_op_t cop;
		ptr_op_t iop;
		emit_t   emit;
		nmode_t  nmode;
		step_t   nxt;
	} uword_t;

	typedef struct packed {
		logic       wr;
		logic       rd;
		asel_t      asel;
		ptr_op_t    fop;
		ptr_op_t    cop;
		ptr_op_t    iop;
		logic       load;
		logic       from_mem;
		logic [1:0] status;
		logic       last;
	} ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic more;
		logic out_busy;
	} stat_t;

	function automatic step_t entry_step(input logic [2:0] op);
		step_t s;
		unique case (op)
			OP_PUSH_FRONT: s = STEP_PUSH_FRONT;
			OP_PUSH_BACK:  s = STEP_PUSH_BACK;
			OP_POP_FRONT:  s = STEP_POP_FRONT;
			OP_POP_BACK:   s = STEP_POP_BACK;
			OP_DUMP_FWD,
			OP_DUMP_BWD:   s = STEP_DUMP;
			default:       s = STEP_FETCH;
		endcase
		return s;
	endfunction

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w.chk   = CHK_NONE;
		w.wr    = 1'b0;
		w.rd    = 1'b0;
		w.asel  = ADDR_FRONT;
		w.fop   = PTR_HOLD;
		w.cop   = PTR_HOLD;
		w.iop   = PTR_HOLD;
		w.emit  = EMIT_NONE;
		w.nmode = NEXT_GOTO;
		w.nxt   = STEP_FETCH;
		unique case (s)
			STEP_FETCH: begin
			end
			STEP_PUSH_FRONT: begin
				w.chk  = CHK_FULL;
				w.wr   = 1'b1;
				w.asel = ADDR_FRONT_DEC;
				w.fop  = PTR_DEC;
				w.cop  = PTR_INC;
				w.emit = EMIT_ZERO;
			end
			STEP_PUSH_BACK: begin
				w.chk  = CHK_FULL;
				w.wr   = 1'b1;
				w.asel = ADDR_BACK;
				w.cop  = PTR_INC;
				w.emit = EMIT_ZERO;
			end
			STEP_POP_FRONT: begin
				w.chk  = CHK_EMPTY;
				w.rd   = 1'b1;
				w.asel = ADDR_FRONT;
				w.fop  = PTR_INC;
				w.cop  = PTR_DEC;
				w.nxt  = STEP_POP_EMIT;
			end
			STEP_POP_BACK: begin
				w.chk  = CHK_EMPTY;
				w.rd   = 1'b1;
				w.asel = ADDR_BACK_LAST;
				w.cop  = PTR_DEC;
				w.nxt  = STEP_POP_EMIT;
			end
			STEP_POP_EMIT: begin
				w.emit = EMIT_MEM;
			end
			STEP_DUMP: begin
				w.chk = CHK_EMPTY;
				w.iop = PTR_CLR;
				w.nxt = STEP_DUMP_READ;
			end
			STEP_DUMP_READ: begin
				w.rd   = 1'b1;
				w.asel = ADDR_DUMP;
				w.iop  = PTR_INC;
				w.nxt  = STEP_DUMP_EMIT;
			end
			STEP_DUMP_EMIT: begin
				w.emit  = EMIT_MEM;
				w.nmode = NEXT_LOOP;
				w.nxt   = STEP_DUMP_READ;
			end
			default: begin
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/deq_seq.sv */
// Microcode sequencer of the double-ended queue: step counter, table lookup and dispatch.
// Depends on deq_pkg for the step codes, the microcode table and the control structs.
`default_nettype none

module deq_seq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire [2:0]            operation,
	output logic                 in_ready,
	input  wire deq_pkg::stat_t  stat,
	output deq_pkg::ctrl_t       ctrl
);
	import deq_pkg::*;

	step_t  pc_q;
	step_t  pc_next;
	uword_t cw;
	logic   hit;
	logic   stall;

	assign cw = ucode(pc_q);

	always_comb begin
		hit = ((cw.chk == CHK_FULL) && stat.full) || ((cw.chk == CHK_EMPTY) && stat.empty);
		stall = ((cw.chk != CHK_NONE) || (cw.emit != EMIT_NONE)) && stat.out_busy;
	end

	always_comb begin
		pc_next = pc_q;
		if (pc_q == STEP_FETCH) begin
			if (in_valid) begin
				pc_next = entry_step(operation);
			end
		end else if (!stall) begin
			if (hit) begin
				pc_next = STEP_FETCH;
			end else if ((cw.nmode == NEXT_LOOP) && !stat.more) begin
				pc_next = STEP_FETCH;
			end else begin
				pc_next = cw.nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_comb begin
		in_ready      = (pc_q == STEP_FETCH);
		ctrl.wr       = 1'b0;
		ctrl.rd       = 1'b0;
		ctrl.asel     = cw.asel;
		ctrl.fop      = PTR_HOLD;
		ctrl.cop      = PTR_HOLD;
		ctrl.iop      = PTR_HOLD;
		ctrl.load     = 1'b0;
		ctrl.from_mem = 1'b0;
		ctrl.status   = ST_OK;
		ctrl.last     = 1'b1;
		if (!stall) begin
			if (hit) begin
				ctrl.load   = 1'b1;
				ctrl.status = (cw.chk == CHK_FULL) ? ST_FULL : ST_EMPTY;
			end else begin
				ctrl.wr       = cw.wr;
				ctrl.rd       = cw.rd;
				ctrl.fop      = cw.fop;
				ctrl.cop      = cw.cop;
				ctrl.iop      = cw.iop;
				ctrl.load     = (cw.emit != EMIT_NONE);
				ctrl.from_mem = (cw.emit == EMIT_MEM);
				ctrl.last     = (cw.nmode == NEXT_LOOP) ? !stat.more : 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/double_ended_queue_core.sv */
// A push is written and its result loaded in its push step; a pop reads the store in its pop step
// and loads the word in the emit step; a dump clears the iterator, then alternates read and emit steps.
// A full or empty refusal loads its status in the first step. An operation is taken only in fetch.
// A result held by out_ready stalls the step that would load the next one.
// Reset clears the step counter, pointers and output valid; the ring store is not cleared.
// Top level: ring store, pointers and output register; depends on deq_pkg and deq_seq.
`default_nettype none

module double_ended_queue_core #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [2:0]         operation,
	input  wire  signed [31:0] push_value,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] word,
	output logic [1:0]         status,
	output logic               last
);
	import deq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;

	ctrl_t ctrl;
	stat_t stat;

	logic [2:0]        op_q;
	logic [WORD_W-1:0] val_q;
	logic [IW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     iter_q;
	logic [WORD_W-1:0] rd_data_q;
	logic [WORD_W-1:0] mem [CAPACITY];

	logic              out_valid_q;
	logic [WORD_W-1:0] word_q;
	logic [1:0]        status_q;
	logic              last_q;

	logic [IW-1:0] front_inc;
	logic [IW-1:0] front_dec;
	logic [CW-1:0] off;
	logic [SW-1:0] sum;
	logic [IW-1:0] addr;

	deq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	always_comb begin
		stat.full     = (count_q == CW'(CAPACITY));
		stat.empty    = (count_q == '0);
		stat.more     = (iter_q != count_q);
		stat.out_busy = out_valid_q && !out_ready;
	end

	always_comb begin
		front_inc = (front_q == IW'(CAPACITY - 1)) ? '0 : front_q + IW'(1);
		front_dec = (front_q == '0) ? IW'(CAPACITY - 1) : front_q - IW'(1);
		unique case (ctrl.asel)
			ADDR_BACK:      off = count_q;
			ADDR_BACK_LAST: off = count_q - CW'(1);
			ADDR_DUMP:      off = (op_q == OP_DUMP_BWD) ? (count_q - CW'(1) - iter_q) : iter_q;
			default:        off = '0;
		endcase
		sum = SW'(front_q) + SW'(off);
		if (sum >= SW'(CAPACITY)) begin
			sum = sum - SW'(CAPACITY);
		end
		addr = (ctrl.asel == ADDR_FRONT_DEC) ? front_dec : sum[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			mem[addr] <= val_q;
		end
		if (ctrl.rd) begin
			rd_data_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= operation;
			val_q <= push_value;
		end
		if (ctrl.load) begin
			word_q   <= ctrl.from_mem ? rd_data_q : '0;
			status_q <= ctrl.status;
			last_q   <= ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctrl.fop)
				PTR_INC: front_q <= front_inc;
				PTR_DEC: front_q <= front_dec;
				default: front_q <= front_q;
			endcase
			case (ctrl.cop)
				PTR_INC: count_q <= count_q + CW'(1);
				PTR_DEC: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
			case (ctrl.iop)
				PTR_CLR: iter_q <= '0;
				PTR_INC: iter_q <= iter_q + CW'(1);
				default: iter_q <= iter_q;
			endcase
			if (ctrl.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign word      = signed'(word_q);
	assign status    = status_q;
	assign last      = last_q;

endmodule

`default_nettype wire

/* rtl/deq_checker.sv */
// Port-level checker of the double-ended queue and its bind to the top level.
// Depends on deq_pkg and on the macros in double_ended_queue_core_assert.svh.
`default_nettype none

`include "double_ended_queue_core_assert.svh"

module deq_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_ready,
	input wire [2:0]         operation,
	input wire signed [31:0] push_value,
	input wire               out_valid,
	input wire               out_ready,
	input wire signed [31:0] word,
	input wire [1:0]         status,
	input wire               last
);
	import deq_pkg::*;

	logic stalled;
	logic refused;
	logic waiting;

	assign stalled = out_valid && !out_ready;
	assign refused = out_valid && (status != ST_OK);
	assign waiting = in_valid && !in_ready;

	`DEQ_ASSERT_NEXT(a_out_valid_holds, stalled, out_valid)
	`DEQ_ASSERT_NEXT(a_out_payload_holds, stalled, $stable(word) && $stable(status) && $stable(last))
	`DEQ_ASSERT_NOW(a_refused_is_last, refused, last)
	`DEQ_ASSERT_NOW(a_refused_word_zero, refused, word == 32'sd0)
	`DEQ_ASSERT_NEXT(a_in_holds, waiting, in_valid && $stable(operation) && $stable(push_value))

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.operation  (operation),
	.push_value (push_value),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.word       (word),
	.status     (status),
	.last       (last)
);

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for double_ended_queue_core: random pushes, pops and dumps
// are checked against a tracked copy of the ring store, result by result.
// Depends on deq_pkg and the double_ended_queue_core RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int DEPTH = CAPACITY_DEF;
	localparam int RANDOM_OPS = 320;
	localparam int QUIET_FROM = 260;
	localparam int STALL_LIMIT = 2000;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		logic [31:0] word;
		logic [1:0]  status;
		logic        last;
	} deq_result_t;

	class deque_scoreboard;
		logic [31:0] ring[DEPTH];
		int unsigned head = 0;
		int unsigned fill = 0;
		deq_result_t pending[$];
		int unsigned fails = 0;

		function void queue_result(logic [31:0] w, logic [1:0] st, logic l);
			deq_result_t r;
			r.word = w;
			r.status = st;
			r.last = l;
			pending.push_back(r);
		endfunction

		function void note_op(logic [2:0] op, logic [31:0] val);
			int unsigned off;
			case (op)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (fill == DEPTH) begin
						queue_result('0, ST_FULL, 1'b1);
					end else begin
						if (op == OP_PUSH_FRONT) begin
							head = (head + DEPTH - 1) % DEPTH;
							ring[head] = val;
						end else begin
							ring[(head + fill) % DEPTH] = val;
						end
						fill++;
						queue_result('0, ST_OK, 1'b1);
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (fill == 0) begin
						queue_result('0, ST_EMPTY, 1'b1);
					end else if (op == OP_POP_FRONT) begin
						queue_result(ring[head], ST_OK, 1'b1);
						head = (head + 1) % DEPTH;
						fill--;
					end else begin
						queue_result(ring[(head + fill - 1) % DEPTH], ST_OK, 1'b1);
						fill--;
					end
				end
				OP_DUMP_FWD, OP_DUMP_BWD: begin
					if (fill == 0) begin
						queue_result('0, ST_EMPTY, 1'b1);
					end else begin
						for (int unsigned i = 0; i < fill; i++) begin
							off = (op == OP_DUMP_FWD) ? i : fill - 1 - i;
							queue_result(ring[(head + off) % DEPTH], ST_OK, i + 1 == fill);
						end
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic [31:0] w, logic [1:0] st, logic l);
			deq_result_t e;
			if (pending.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result: word %0d status %0d last %0d",
						$signed(w), st, l);
			end else begin
				e = pending.pop_front();
				if (e.word !== w || e.status !== st || e.last !== l) begin
					fails++;
					if (fails <= 10)
						$display("mismatch: expected word %0d status %0d last %0d, got %0d %0d %0d",
							$signed(e.word), e.status, e.last, $signed(w), st, l);
				end
			end
		endfunction

		function int unsigned outstanding();
			return pending.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         operation;
	logic signed [31:0] push_value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] word;
	logic [1:0]         status;
	logic               last;

	deque_scoreboard tracker = new();
	bit quiet = 1'b0;
	int ops_sent = 0;
	int idle_cycles = 0;

	double_ended_queue_core #(.CAPACITY(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.word(word),
		.status(status),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_PUSH_FRONT;
		push_value = '0;
		out_ready = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_result(word, status, last);
			if (in_valid && in_ready)
				tracker.note_op(operation, push_value);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		@(negedge clk);
		forever begin
			if (!quiet && arst_n && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(input logic [2:0] op, input logic [31:0] val);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		push_value <= val;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (op <= OP_DUMP_BWD)
			ops_sent++;
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.outstanding() != 0)
			@(negedge clk);
	endtask

	initial begin
		int n;
		logic [2:0] op;
		bit drained_mid;
		drained_mid = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_op(OP_POP_FRONT, 32'h0000_0000);
		send_op(OP_DUMP_BWD, 32'hFFFF_FFFF);
		send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_op(OP_PUSH_BACK, 32'h8000_0000);
		send_op(OP_POP_FRONT, pick_word());
		send_op(OP_POP_BACK, pick_word());
		send_op(OP_SPARE_LO, 32'hFFFF_FFFF);
		send_op(OP_SPARE_HI, 32'h0000_0000);
		for (int i = 0; i < DEPTH; i++)
			send_op(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
				(i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF :
				(i[1] ? 32'hAAAA_AAAA : 32'h5555_5555) ^ i);
		send_op(OP_PUSH_FRONT, pick_word());
		send_op(OP_PUSH_BACK, pick_word());
		send_op(OP_DUMP_FWD, pick_word());
		send_op(OP_DUMP_BWD, pick_word());
		wait_for_drain();

		ops_sent = 0;
		while (ops_sent < RANDOM_OPS) begin
			if (ops_sent >= QUIET_FROM)
				quiet = 1'b1;
			if (!drained_mid && ops_sent >= RANDOM_OPS / 2) begin
				wait_for_drain();
				drained_mid = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = $urandom_range(1, 18);
					repeat (n) send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
						pick_word());
				end
				3, 4: begin
					n = $urandom_range(1, 18);
					repeat (n) send_op($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
						pick_word());
				end
				5, 6: send_op($urandom_range(0, 1) ? OP_DUMP_BWD : OP_DUMP_FWD, pick_word());
				7: begin
					n = $urandom_range(1, 12);
					repeat (n) begin
						send_op(OP_POP_FRONT, pick_word());
						send_op(OP_PUSH_BACK, pick_word());
					end
				end
				default: begin
					op = 3'($urandom_range(0, 7));
					send_op(op, pick_word());
				end
			endcase
		end

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (tracker.fails == 0 && tracker.outstanding() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

/* double_ended_queue_core.f */
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_seq.sv
rtl/double_ended_queue_core.sv
rtl/deq_checker.sv
verif/tb_top.sv
